// ===== src/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg: shared types and constants of the nearest timestamp search
// Table geometry, field widths, operation and register codes, and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package nts_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LIMIT_W     = ADDR_W + 1;

  localparam int TIME_W      = 64;
  localparam int INDEX_W     = 12;
  localparam int COUNT_W     = 13;
  localparam int RESULT_W    = 13;
  localparam int CFG_INDEX_W = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT  = 2'd2;

  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic scan_start;  // rewind the read pointer
    logic scan;        // read one entry and test the previous one
    logic measure;     // form both distances
    logic decide;      // pick the nearer entry
    logic load_out;    // move the result into the output register
  } nts_cmd_t;

  typedef struct packed {
    logic win_ok;      // query time inside the window
    logic limit_zero;  // no entries in use
    logic hit;         // entry at or after the query time found
    logic exhausted;   // every entry in use was tested
  } nts_status_t;

endpackage

// ===== src/nts_datapath.sv =====
// ----------------------------------------------------------------------------
// nts_datapath: timestamp table, configuration registers and scan datapath
// Holds the table memory, the window and count registers, the scan pointer
// and the distance logic that picks the nearer of two neighboring entries.
// ----------------------------------------------------------------------------
module nts_datapath
  import nts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  nts_cmd_t               cmd,
  output nts_status_t            status,
  input  logic                   op,
  input  logic [INDEX_W-1:0]     entry_index,
  input  logic [TIME_W-1:0]      time_value,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]      cfg_data,
  output logic [RESULT_W-1:0]    record_number
);

  logic [TIME_W-1:0]   mem [TABLE_DEPTH];

  logic [TIME_W-1:0]   window_start;
  logic [TIME_W-1:0]   window_end;
  logic [COUNT_W-1:0]  entry_count;

  logic [TIME_W-1:0]   key;
  logic [LIMIT_W-1:0]  limit;
  logic [LIMIT_W-1:0]  rd_addr;
  logic                rd_en;
  logic                rd_vld;
  logic [ADDR_W-1:0]   rd_num;
  logic [TIME_W-1:0]   rd_data;
  logic                key_le_cur;

  logic [TIME_W-1:0]   prev;
  logic [TIME_W-1:0]   cur;
  logic [ADDR_W-1:0]   hit_num;
  logic [TIME_W-1:0]   d_cur;
  logic [TIME_W-1:0]   d_prev;
  logic                prev_lt;
  logic                first;
  logic [RESULT_W-1:0] result;
  logic                wr_en;

  // Counts above the table depth saturate for the scan.
  assign limit = (32'(entry_count) > TABLE_DEPTH) ? LIMIT_W'(TABLE_DEPTH)
                                                  : LIMIT_W'(entry_count);

  assign rd_en      = cmd.scan && (rd_addr < limit);
  assign key_le_cur = $signed(key) <= $signed(rd_data);
  assign wr_en      = cmd.accept && (op == OP_WRITE) && (32'(entry_index) < TABLE_DEPTH);

  assign status.win_ok     = ($signed(key) >= $signed(window_start)) &&
                             ($signed(key) <= $signed(window_end));
  assign status.limit_zero = (limit == '0);
  assign status.hit        = rd_vld && key_le_cur;
  assign status.exhausted  = !rd_vld && !(rd_addr < limit);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(entry_index)] <= time_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '0;
      entry_count  <= '0;
      rd_addr      <= '0;
      rd_vld       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_START: window_start <= cfg_data;
          REG_WINDOW_END:   window_end   <= cfg_data;
          REG_ENTRY_COUNT:  entry_count  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        rd_addr <= '0;
      end else if (rd_en) begin
        rd_addr <= rd_addr + 1'b1;
      end
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key    <= time_value;
      result <= '0;
    end
    if (rd_en) begin
      rd_num <= rd_addr[ADDR_W-1:0];
    end
    if (cmd.scan && rd_vld) begin
      if (key_le_cur) begin
        cur     <= rd_data;
        hit_num <= rd_num;
      end else begin
        prev <= rd_data;
      end
    end
    if (cmd.measure) begin
      // The current entry is at or after the key, so its distance fits in
      // 64 unsigned bits; the earlier one is only used when below the key.
      d_cur   <= cur - key;
      d_prev  <= key - prev;
      prev_lt <= $signed(prev) < $signed(key);
      first   <= (hit_num == '0);
    end
    if (cmd.decide) begin
      if (first) begin
        result <= RESULT_W'(1);
      end else if (prev_lt && (d_prev < d_cur)) begin
        result <= RESULT_W'(hit_num);
      end else begin
        result <= RESULT_W'({1'b0, hit_num} + 1'b1);
      end
    end
    if (cmd.load_out) begin
      record_number <= result;
    end
  end

endmodule

// ===== src/nts_ctrl.sv =====
// ----------------------------------------------------------------------------
// nts_ctrl: sequencer of the nearest timestamp search
// Takes items, steps the datapath through window check, scan and decision,
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module nts_ctrl
  import nts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  output logic        out_valid,
  input  logic        out_stall,
  output nts_cmd_t    cmd,
  input  nts_status_t status
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    SCAN,
    DIST,
    DECIDE,
    EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == IDLE) && in_valid;
    cmd.scan_start = (state == CHECK);
    cmd.scan       = (state == SCAN);
    cmd.measure    = (state == DIST);
    cmd.decide     = (state == DECIDE);
    cmd.load_out   = (state == EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.accept) begin
            state <= (op == OP_QUERY) ? CHECK : EMIT;
          end
        end
        CHECK: begin
          if (!status.win_ok || status.limit_zero) begin
            state <= EMIT;
          end else begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (status.hit) begin
            state <= DIST;
          end else if (status.exhausted) begin
            state <= EMIT;
          end
        end
        DIST:   state <= DECIDE;
        DECIDE: state <= EMIT;
        EMIT: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("output register loaded while a result was stalled");

  // A new result appears only from the emit step.
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == EMIT))
    else $error("output valid rose outside the emit step");

  // After an item is taken the input side stays closed for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> in_stall)
    else $error("input open right after an accepted item");

  // Datapath steps never overlap.
  a_steps_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.scan_start, cmd.scan, cmd.measure, cmd.decide}))
    else $error("more than one datapath step in a cycle");

  // A hit and exhaustion are never reported together while scanning entries.
  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    status.hit && cmd.scan |-> !status.exhausted)
    else $error("scan reported a hit and exhaustion together");

endmodule

// ===== src/nearest_timestamp_search.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_search: table of timestamps with nearest-entry lookup
// Stores signed 64-bit timestamps in a 4096-entry table and answers, for a
// query time, the 1-based number of the nearest entry around the first one
// at or after that time.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the input channel (in_valid, in_stall) carrying op,
// entry_index and time_value; an item is taken at a clock edge with in_valid
// high and in_stall low. Every item yields exactly one item on the output
// channel (out_valid, out_stall) carrying record_number. A write item (op 0)
// stores time_value at entry_index and answers 0. A query item (op 1) answers
// 0 when the time lies outside the window or nothing qualifies.
// A write goes from acceptance to the emit step. A query outside the window
// or against an empty table goes from the window check to emit; others scan
// from entry 0 to the first entry at or after the time, then measure, decide
// and emit, or emit when the entries in use run out. The linear scan through
// the single-read-port table memory, one entry a cycle, sets the rate. The
// block takes one item at a time; in_stall is high while an item is
// in work. The output register lets the next item start while a result is
// held. When the receiver stalls, the result stays put and a finished item
// waits in its final step until the output register frees. The configuration
// port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready: index 0
// sets window_start, 1 window_end, 2 entry_count; index 3 is ignored. Reset
// (rst, synchronous) clears the registers and control, and needs no clearing
// pass; table entries are undefined until written.
// ----------------------------------------------------------------------------
module nearest_timestamp_search
  import nts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [INDEX_W-1:0]     entry_index,
  input  logic [TIME_W-1:0]      time_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [RESULT_W-1:0]    record_number,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]      cfg_data
);

  nts_cmd_t    cmd;
  nts_status_t status;

  // Configuration writes are taken in any cycle; the user must issue them only
  // while the block is idle, and the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  nts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  nts_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .op            (op),
    .entry_index   (entry_index),
    .time_value    (time_value),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .record_number (record_number)
  );

endmodule

// ===== verif/nearest_timestamp_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_timestamp_search_tb: self-checking bench for the timestamp search
// Drives write and query items, keeps its own copy of the timestamp table and
// the window and count registers, predicts each record_number and compares
// every output item in order. Idling on both channels changes per phase.
// ----------------------------------------------------------------------------
module nearest_timestamp_search_tb;
  import nts_pkg::*;

  // Index 3 of the configuration port has no register behind it.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};

  localparam int RANDOM_ITEMS = 90;
  localparam int REPORT_LIMIT = 10;

  // Holds a private copy of the table and registers, works out the expected
  // record_number of every accepted item and checks the output items in order.
  class record_scoreboard;
    logic signed [TIME_W-1:0] stamps [TABLE_DEPTH];
    bit                       written [TABLE_DEPTH];
    logic signed [TIME_W-1:0] win_start;
    logic signed [TIME_W-1:0] win_end;
    logic [COUNT_W-1:0]       count;
    logic [RESULT_W-1:0]      expected_records [$];
    int                       failures;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        stamps[i]  = '0;
        written[i] = 1'b0;
      end
      win_start = '0;
      win_end   = '0;
      count     = '0;
      failures  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [TIME_W-1:0] data);
      case (idx)
        REG_WINDOW_START: win_start = data;
        REG_WINDOW_END:   win_end = data;
        REG_ENTRY_COUNT:  count = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Scan for the first entry at or after t and pick the nearer of it and
    // its predecessor. Distances are taken at 65 bits so they never wrap.
    // span is how many slots from 0 the block may touch: the stopping entry,
    // one slot of read-ahead past it and one more as margin.
    function void nearest_record(input logic signed [TIME_W-1:0] t,
                                 output logic [RESULT_W-1:0] rec, output int span);
      int lim;
      logic signed [TIME_W:0] to_cur;
      logic signed [TIME_W:0] to_prev;
      rec  = '0;
      span = 0;
      if (t < win_start || t > win_end) return;
      lim  = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
      span = lim;
      for (int i = 0; i < lim; i++) begin
        if (stamps[i] >= t) begin
          span = (i + 3 < lim) ? i + 3 : lim;
          if (i == 0) begin
            rec = RESULT_W'(1);
          end else begin
            to_cur = stamps[i] - t;
            rec    = RESULT_W'(i + 1);
            if (stamps[i-1] < t) begin
              to_prev = t - stamps[i-1];
              if (to_prev < to_cur) rec = RESULT_W'(i);
            end
          end
          break;
        end
      end
    endfunction

    // True when a query at t reads only slots that were written.
    function bit query_defined(logic signed [TIME_W-1:0] t);
      logic [RESULT_W-1:0] rec;
      int span;
      nearest_record(t, rec, span);
      for (int j = 0; j < span; j++) if (!written[j]) return 1'b0;
      return 1'b1;
    endfunction

    function void take_item(logic o, logic [INDEX_W-1:0] idx,
                            logic signed [TIME_W-1:0] t);
      logic [RESULT_W-1:0] rec;
      int span;
      if (o == OP_WRITE) begin
        stamps[idx]  = t;
        written[idx] = 1'b1;
        expected_records.push_back('0);
      end else begin
        nearest_record(t, rec, span);
        expected_records.push_back(rec);
      end
    endfunction

    function void check_record(logic [RESULT_W-1:0] got);
      logic [RESULT_W-1:0] want;
      if (expected_records.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected output item: record_number %0d, none outstanding", got);
        return;
      end
      want = expected_records.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("record_number mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction

    function int pending();
      return expected_records.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   op = OP_WRITE;
  logic [INDEX_W-1:0]     entry_index = '0;
  logic [TIME_W-1:0]      time_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [RESULT_W-1:0]    record_number;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]      cfg_data = '0;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int item_total = 0;

  record_scoreboard sb;

  nearest_timestamp_search dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .entry_index  (entry_index),
    .time_value   (time_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_number(record_number),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: an item moves when out_valid is high and out_stall low at
  // the edge. Signals are read before this edge's updates land, so the
  // sampled pair is the one the block saw. The stall for the next cycle is
  // drawn fresh every cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_record(record_number);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one item, after a random gap, and hold it until the block takes it.
  // in_valid is left high on return, so a following item goes out back to
  // back without valid dropping in between.
  task automatic send_item(input logic o, input logic [INDEX_W-1:0] idx,
                           input logic signed [TIME_W-1:0] t);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    entry_index <= idx;
    time_value  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_item(o, idx, t);
    item_total++;
  endtask

  // Stop sending and wait until every outstanding result has come back.
  // Every item yields a result, so the block is idle afterwards.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [TIME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Query time aimed at the interesting spots of a table of n entries:
  // right at or next to an entry, the midpoint of two neighbors (a tie),
  // the window edges, the extremes, or anything at all.
  function automatic logic signed [TIME_W-1:0] pick_query(int n);
    logic signed [TIME_W-1:0] a;
    logic signed [TIME_W-1:0] b;
    logic signed [TIME_W:0]   mid;
    int j;
    int roll;
    j    = $urandom_range(n - 1);
    roll = $urandom_range(99);
    a    = sb.stamps[j];
    b    = sb.stamps[(j + 1 < n) ? j + 1 : j];
    if (roll < 40) return a + TIME_W'($urandom_range(6)) - TIME_W'(3);
    if (roll < 60) begin
      mid = a + b;
      mid = mid >>> 1;
      return mid[TIME_W-1:0] + TIME_W'($urandom_range(1));
    end
    if (roll < 75) return {$urandom, $urandom};
    if (roll < 85) begin
      case ($urandom_range(3))
        0:       return T_MIN;
        1:       return T_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    case ($urandom_range(3))
      0:       return sb.win_start - 1;
      1:       return sb.win_start;
      2:       return sb.win_end;
      default: return sb.win_end + 1;
    endcase
  endfunction

  // Short hand-picked sequence: empty table, extremes of time and index,
  // ties, the first entry hitting, an unsorted table, a scan that runs out,
  // window edges, an inverted window, a count beyond the table and a write
  // to the unused register index.
  task automatic run_directed();
    send_item(OP_QUERY, '0, '0);
    send_item(OP_QUERY, '1, '1);
    send_item(OP_WRITE, INDEX_W'(0), T_MIN);
    send_item(OP_WRITE, INDEX_W'(1), -64'sd100);
    send_item(OP_WRITE, INDEX_W'(2), '0);
    send_item(OP_WRITE, INDEX_W'(3), 64'sd100);
    send_item(OP_WRITE, INDEX_W'(4), T_MAX);
    send_item(OP_WRITE, '1, 64'sd12345);
    drain();
    write_reg(REG_WINDOW_START, T_MIN);
    write_reg(REG_WINDOW_END, T_MAX);
    write_reg(REG_ENTRY_COUNT, 64'd5);
    // Must leave the window and count untouched.
    write_reg(REG_SPARE, '1);
    send_item(OP_QUERY, '0, T_MIN);
    send_item(OP_QUERY, '0, T_MIN + 1);
    send_item(OP_QUERY, '0, -64'sd60);
    send_item(OP_QUERY, '0, -64'sd50);
    send_item(OP_QUERY, '0, 64'sd101);
    send_item(OP_QUERY, '0, T_MAX);
    // Break the ordering: slot 2 now lies above slot 3.
    send_item(OP_WRITE, INDEX_W'(2), 64'sd500);
    send_item(OP_QUERY, '0, 64'sd200);
    drain();
    // With four entries nothing reaches 600, so the scan runs out.
    write_reg(REG_ENTRY_COUNT, 64'd4);
    send_item(OP_QUERY, '0, 64'sd600);
    drain();
    write_reg(REG_WINDOW_START, -64'sd100);
    write_reg(REG_WINDOW_END, 64'sd100);
    send_item(OP_QUERY, '0, -64'sd101);
    send_item(OP_QUERY, '0, -64'sd100);
    send_item(OP_QUERY, '0, 64'sd100);
    send_item(OP_QUERY, '0, 64'sd101);
    drain();
    write_reg(REG_WINDOW_START, 64'sd10);
    write_reg(REG_WINDOW_END, -64'sd10);
    send_item(OP_QUERY, '0, '0);
    drain();
    // All ones in the count field; the scan saturates at the table depth.
    write_reg(REG_WINDOW_START, T_MIN);
    write_reg(REG_WINDOW_END, T_MAX);
    write_reg(REG_ENTRY_COUNT, '1);
    send_item(OP_QUERY, '0, -64'sd100);
  endtask

  // One random episode: load a small table from slot 0 up, mostly in
  // ascending order with a random scale, then program the window and count
  // and fire a handful of queries. Queries that would read a slot never
  // written are replaced by a write.
  task automatic run_episode();
    int n;
    int scale;
    int nq;
    int cnt;
    int roll;
    int tries;
    logic signed [TIME_W-1:0] t;
    logic signed [TIME_W-1:0] step;
    logic signed [TIME_W-1:0] ws;
    logic signed [TIME_W-1:0] we;
    logic [TIME_W-1:0]        cfg_word;
    bit                       unsorted;
    n = $urandom_range(24, 1);
    case ($urandom_range(3))
      0:       scale = 3;
      1:       scale = 10;
      2:       scale = 30;
      default: scale = 58;
    endcase
    // Start and step sizes are chosen so the running sum never wraps.
    if (scale == 58) t = T_MIN + ({$urandom, $urandom} >> 4);
    else t = $signed({$urandom, $urandom}) >>> (59 - scale);
    unsorted = ($urandom_range(4) == 0);
    for (int i = 0; i < n; i++) begin
      if (unsorted && $urandom_range(3) == 0)
        send_item(OP_WRITE, INDEX_W'(i), {$urandom, $urandom});
      else
        send_item(OP_WRITE, INDEX_W'(i), t);
      step = {$urandom, $urandom} >> (TIME_W - scale);
      t    = t + step;
    end
    drain();

    roll = $urandom_range(99);
    if (roll < 50) begin
      ws = T_MIN;
      we = T_MAX;
    end else if (roll < 70) begin
      ws = sb.stamps[0] - TIME_W'($urandom_range(50));
      we = sb.stamps[n-1] + TIME_W'($urandom_range(50));
    end else if (roll < 85) begin
      ws = sb.stamps[$urandom_range(n - 1)];
      we = sb.stamps[$urandom_range(n - 1)];
      if (ws > we) begin
        t  = ws;
        ws = we;
        we = t;
      end
    end else if (roll < 95) begin
      ws = {$urandom, $urandom};
      we = {$urandom, $urandom};
    end else begin
      ws = sb.stamps[0] + 1;
      we = sb.stamps[0];
    end
    write_reg(REG_WINDOW_START, ws);
    write_reg(REG_WINDOW_END, we);

    roll = $urandom_range(99);
    if (roll < 60) cnt = n;
    else if (roll < 70) cnt = $urandom_range(n);
    else if (roll < 78) cnt = 0;
    else if (roll < 90) cnt = n + $urandom_range(10, 1);
    else cnt = $urandom_range(8191, TABLE_DEPTH);
    // Bits above the count field are junk that the block must drop.
    cfg_word = {$urandom, $urandom};
    cfg_word[COUNT_W-1:0] = COUNT_W'(cnt);
    write_reg(REG_ENTRY_COUNT, cfg_word);
    if ($urandom_range(9) == 0) write_reg(REG_SPARE, {$urandom, $urandom});

    nq = $urandom_range(8, 3);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(9) == 0) begin
        send_item(OP_WRITE, INDEX_W'($urandom_range(TABLE_DEPTH - 1)),
                  {$urandom, $urandom});
      end else begin
        tries = 0;
        do begin
          t = pick_query(n);
          tries++;
        end while (!sb.query_defined(t) && tries < 20);
        if (sb.query_defined(t))
          send_item(OP_QUERY, INDEX_W'($urandom_range(TABLE_DEPTH - 1)), t);
        else
          send_item(OP_WRITE, INDEX_W'($urandom_range(n - 1)), t);
      end
    end
  endtask

  // Main sequence. Reset once, then the directed items and three random
  // phases: sender idles 12% and receiver 56%, then the other way round,
  // then neither idles. Each phase stops once its share of items has gone
  // out. Every configuration change sits behind a drain, so the sender
  // also pauses there until all results are in.
  initial begin
    int mark;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 56;
    run_directed();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mark = item_total;
      while (item_total - mark < RANDOM_ITEMS / 3) run_episode();
    end

    // Let any stray output item show up before the verdict.
    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
